// File: rtl/ohi_pkg.sv
// Package for the open addressing hash insert block.
// Holds table constants, field widths, probe and status codes and the controller state type.
// No dependencies.
`default_nettype none
package ohi_pkg;
	localparam int TABLE_CAPACITY = 1024;
	localparam int MAX_KEY_LEN    = 32;
	localparam int ADDR_W         = $clog2(TABLE_CAPACITY);
	localparam int SIZE_W         = ADDR_W + 1;
	localparam int SUM_W          = 13;
	localparam int ENTRY_W        = SUM_W + 1;
	localparam int KLEN_W         = $clog2(MAX_KEY_LEN + 1);
	localparam int DIV_STEPS      = SUM_W;
	localparam int SHIFT_W        = SIZE_W + SUM_W;
	localparam logic [SUM_W-1:0] SUM_LIMIT = '1;
	localparam int OUT_DATA_W     = 56;

	localparam logic [1:0] CFG_INITIAL_SIZE = 2'd0;
	localparam logic [1:0] CFG_FILL_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_PROBE_MODE   = 2'd2;

	localparam logic [1:0] MODE_LINEAR = 2'd0;
	localparam logic [1:0] MODE_QUAD   = 2'd1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic REQ_CLEAR = 1'b0;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_GCHK,
		S_SRC_RD,
		S_SRC_CHK,
		S_DINIT,
		S_DIV,
		S_PRB_RD,
		S_PRB_CHK,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

// File: rtl/open_addressing_hash_insert.sv
// Key bytes are taken in the idle state; the final byte is followed by a fill check,
// bit-serial reduction of base and step, a read and a check per probe, and a state
// that presents the result. A doubling first clears the new bank (one entry a cycle)
// and tries to re-place every old entry. Reset and a clear request clear all 1024
// entries of both banks, taking no input meanwhile. One item is worked on at a time.
`default_nettype none
module open_addressing_hash_insert
	import ohi_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,  // key_byte
	input  wire logic                  s_tlast,  // key_last
	input  wire logic                  s_tuser,  // req_type
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// slot_index, collision_count, grew_now, table_size_now, resize_total,
	// worst_collisions, insert_status, zero fill
	output logic [OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [10:0]           cfg_data
);
	state_t state_q, state_d;

	logic [SIZE_W-1:0] isz_q;
	logic [8:0]        fill_q;
	logic [1:0]        mode_q;

	logic              active_q;
	logic [SIZE_W-1:0] size_q, cnt_q, maxc_q;
	logic [SUM_W-1:0]  ksum_q, key_q, psum_q, rem_q;
	logic [KLEN_W-1:0] klen_q;
	logic [3:0]        dbl_q;
	logic              clr_all_q;
	logic [SIZE_W-1:0] clr_cnt_q, k_q, pi_q, ps_q;
	logic              pb_q, rehash_q, grew_q, refused_q;
	logic [ADDR_W-1:0] d_q, inc_q, j_q, slot_q;
	logic [3:0]        b_q;
	logic [SIZE_W-1:0] coll_q;
	logic [1:0]        status_q;
	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [ENTRY_W-1:0] mem_a [TABLE_CAPACITY];
	logic [ENTRY_W-1:0] mem_b [TABLE_CAPACITY];
	logic [ENTRY_W-1:0] rd_a_q, rd_b_q, wd;
	logic [ADDR_W-1:0]  ra, wa;
	logic               we_a, we_b;

	logic               acc, free, pi_last, k_end, clr_end, grow_need, grow_ok;
	logic [ENTRY_W-1:0] src_ent;
	logic [SIZE_W-1:0]  jn, dn, jnext, dnext, isz_clamp;
	logic [SUM_W:0]     ksum_add;
	logic [SUM_W-1:0]   ksum_next;
	logic [SHIFT_W-1:0] shifted;
	logic [19:0]        lim_prod;

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign free     = !(pb_q ? rd_b_q[ENTRY_W-1] : rd_a_q[ENTRY_W-1]);
	assign src_ent  = active_q ? rd_b_q : rd_a_q;
	assign pi_last  = (pi_q + SIZE_W'(1)) == ps_q;
	assign k_end    = (k_q + SIZE_W'(1)) == size_q;
	assign clr_end  = clr_cnt_q == (clr_all_q ? SIZE_W'(TABLE_CAPACITY - 1) : ps_q - SIZE_W'(1));
	assign lim_prod = 20'(fill_q) * 20'(size_q);
	assign grow_need = {1'b0, cnt_q, 8'd0} > lim_prod;
	assign grow_ok  = {size_q, 1'b0} <= (SIZE_W+1)'(TABLE_CAPACITY);

	assign jn    = {1'b0, j_q} + {1'b0, d_q};
	assign jnext = (jn >= ps_q) ? jn - ps_q : jn;
	assign dn    = {1'b0, d_q} + {1'b0, inc_q};
	assign dnext = (dn >= ps_q) ? dn - ps_q : dn;
	assign shifted = SHIFT_W'(ps_q) << b_q;

	assign isz_clamp = (isz_q == '0) ? SIZE_W'(1) :
		(isz_q > SIZE_W'(TABLE_CAPACITY)) ? SIZE_W'(TABLE_CAPACITY) : isz_q;
	assign ksum_add  = {1'b0, ksum_q} + (SUM_W+1)'(s_tdata);
	assign ksum_next = (klen_q >= KLEN_W'(MAX_KEY_LEN)) ? ksum_q :
		(ksum_add[SUM_W] ? SUM_LIMIT : ksum_add[SUM_W-1:0]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				if (clr_end) state_d = clr_all_q ? S_IDLE : S_SRC_RD;
			end
			S_IDLE: begin
				if (acc) begin
					if (s_tuser == REQ_CLEAR) state_d = S_CLR;
					else if (s_tlast) state_d = S_GCHK;
				end
			end
			S_GCHK:    state_d = (grow_need && grow_ok) ? S_CLR : S_DINIT;
			S_SRC_RD:  state_d = S_SRC_CHK;
			S_SRC_CHK: state_d = (src_ent[ENTRY_W-1] || k_end) ? S_DINIT : S_SRC_RD;
			S_DINIT:   state_d = S_DIV;
			S_DIV:     state_d = (b_q == '0) ? S_PRB_RD : S_DIV;
			S_PRB_RD:  state_d = S_PRB_CHK;
			S_PRB_CHK: begin
				if (free || pi_last) begin
					if (rehash_q) state_d = k_end ? S_DINIT : S_SRC_RD;
					else state_d = S_OUT;
				end else begin
					state_d = S_PRB_RD;
				end
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we_a = 1'b0;
		we_b = 1'b0;
		ra   = (state_q == S_SRC_RD) ? k_q[ADDR_W-1:0] : j_q;
		wa   = (state_q == S_CLR) ? clr_cnt_q[ADDR_W-1:0] : j_q;
		wd   = (state_q == S_CLR) ? '0 : {1'b1, psum_q};
		case (state_q)
			S_CLR: begin
				we_a = clr_all_q || !pb_q;
				we_b = clr_all_q || pb_q;
			end
			S_PRB_CHK: begin
				we_a = free && !pb_q;
				we_b = free && pb_q;
			end
			default: begin
				we_a = 1'b0;
				we_b = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_a) mem_a[wa] <= wd;
		if (we_b) mem_b[wa] <= wd;
		rd_a_q <= mem_a[ra];
		rd_b_q <= mem_b[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			isz_q      <= SIZE_W'(16);
			fill_q     <= 9'd192;
			mode_q     <= 2'd2;
			active_q   <= 1'b0;
			size_q     <= SIZE_W'(16);
			cnt_q      <= '0;
			maxc_q     <= '0;
			ksum_q     <= '0;
			klen_q     <= '0;
			dbl_q      <= '0;
			clr_all_q  <= 1'b1;
			clr_cnt_q  <= '0;
			pb_q       <= 1'b0;
			rehash_q   <= 1'b0;
			grew_q     <= 1'b0;
			refused_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_INITIAL_SIZE: isz_q  <= cfg_data;
					CFG_FILL_LIMIT:   fill_q <= cfg_data[8:0];
					CFG_PROBE_MODE:   mode_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: clr_cnt_q <= clr_cnt_q + SIZE_W'(1);
				S_IDLE: begin
					if (acc) begin
						if (s_tuser == REQ_CLEAR) begin
							active_q  <= 1'b0;
							size_q    <= isz_clamp;
							cnt_q     <= '0;
							maxc_q    <= '0;
							ksum_q    <= '0;
							klen_q    <= '0;
							dbl_q     <= '0;
							clr_all_q <= 1'b1;
							clr_cnt_q <= '0;
						end else if (s_tlast) begin
							key_q  <= ksum_next;
							ksum_q <= '0;
							klen_q <= '0;
						end else begin
							ksum_q <= ksum_next;
							if (klen_q < KLEN_W'(MAX_KEY_LEN)) klen_q <= klen_q + KLEN_W'(1);
						end
					end
				end
				S_GCHK: begin
					grew_q    <= 1'b0;
					refused_q <= grow_need && !grow_ok;
					if (grow_need && grow_ok) begin
						pb_q      <= !active_q;
						ps_q      <= {size_q[SIZE_W-2:0], 1'b0};
						clr_all_q <= 1'b0;
						clr_cnt_q <= '0;
						k_q       <= '0;
						rehash_q  <= 1'b1;
					end else begin
						pb_q     <= active_q;
						ps_q     <= size_q;
						psum_q   <= key_q;
						rehash_q <= 1'b0;
					end
				end
				S_SRC_CHK: begin
					if (src_ent[ENTRY_W-1]) begin
						psum_q <= src_ent[SUM_W-1:0];
					end else if (k_end) begin
						active_q <= !active_q;
						size_q   <= ps_q;
						if (dbl_q != 4'hF) dbl_q <= dbl_q + 4'd1;
						grew_q   <= 1'b1;
						psum_q   <= key_q;
						rehash_q <= 1'b0;
					end else begin
						k_q <= k_q + SIZE_W'(1);
					end
				end
				S_DINIT: begin
					rem_q <= psum_q;
					b_q   <= 4'(DIV_STEPS - 1);
					pi_q  <= '0;
					case (mode_q)
						MODE_LINEAR: begin
							d_q   <= ADDR_W'(1);
							inc_q <= '0;
						end
						MODE_QUAD: begin
							d_q   <= ADDR_W'(2);
							inc_q <= ADDR_W'(2);
						end
						default: begin
							d_q   <= ADDR_W'(40);
							inc_q <= ADDR_W'(58);
						end
					endcase
				end
				S_DIV: begin
					b_q <= b_q - 4'd1;
					if (SHIFT_W'(rem_q) >= shifted) rem_q <= rem_q - shifted[SUM_W-1:0];
					if (SHIFT_W'(d_q) >= shifted) d_q <= d_q - shifted[ADDR_W-1:0];
					if (SHIFT_W'(inc_q) >= shifted) inc_q <= inc_q - shifted[ADDR_W-1:0];
					if (b_q == '0) begin
						if (SHIFT_W'(rem_q) >= shifted) begin
							j_q <= ADDR_W'(rem_q - shifted[SUM_W-1:0]);
						end else begin
							j_q <= rem_q[ADDR_W-1:0];
						end
					end
				end
				S_PRB_CHK: begin
					if (free || pi_last) begin
						if (rehash_q) begin
							if (!free && cnt_q != '0) cnt_q <= cnt_q - SIZE_W'(1);
							if (k_end) begin
								active_q <= !active_q;
								size_q   <= ps_q;
								if (dbl_q != 4'hF) dbl_q <= dbl_q + 4'd1;
								grew_q   <= 1'b1;
								psum_q   <= key_q;
								rehash_q <= 1'b0;
							end else begin
								k_q <= k_q + SIZE_W'(1);
							end
						end else if (free) begin
							if (cnt_q != '1) cnt_q <= cnt_q + SIZE_W'(1);
							if (pi_q > maxc_q) maxc_q <= pi_q;
							slot_q   <= j_q;
							coll_q   <= pi_q;
							status_q <= refused_q ? ST_REFUSED : ST_OK;
						end else begin
							slot_q   <= '0;
							coll_q   <= ps_q;
							status_q <= ST_FULL;
						end
					end else begin
						pi_q  <= pi_q + SIZE_W'(1);
						j_q   <= jnext[ADDR_W-1:0];
						d_q   <= dnext[ADDR_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {6'd0, status_q, maxc_q, dbl_q, size_q, grew_q, coll_q, slot_q};
		end
	end

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PRB_CHK |-> (SIZE_W'(j_q) < ps_q) && (pi_q < ps_q))
		else $error("probe slot or index beyond table size");
	a_step_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PRB_RD |-> (SIZE_W'(d_q) < ps_q) && (SIZE_W'(inc_q) < ps_q))
		else $error("probe step not reduced below table size");
	a_size_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(size_q != '0) && (size_q <= SIZE_W'(TABLE_CAPACITY)))
		else $error("table size out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser && s_tlast |=> state_q == S_GCHK)
		else $error("final key byte did not start an insert");
endmodule
`default_nettype wire

// File: dv/ohi_checker.sv
// Checker for the open addressing hash insert block: watches both stream channels and
// the configuration port, predicts every result, and compares it. Depends on ohi_pkg.
`default_nettype none
module ohi_checker
	import ohi_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [7:0]            s_tdata,
	input  wire logic                  s_tlast,
	input  wire logic                  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [10:0]           cfg_data,
	output int                         fails,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [9:0]  slot;
		logic [10:0] coll;
		logic        grew;
		logic [10:0] size;
		logic [3:0]  resizes;
		logic [10:0] worst;
		logic [1:0]  status;
	} insert_result_t;

	insert_result_t placements[$];

	logic [ENTRY_W-1:0] banks [2][TABLE_CAPACITY];
	logic        bank_sel;
	int          size_now, entries, key_sum, key_len, doublings, worst_seen;
	logic [10:0] init_size_reg;
	logic [8:0]  fill_limit_reg;
	logic [1:0]  probe_mode_reg;

	task automatic report(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	function automatic int step_offset(input int i);
		if (probe_mode_reg == MODE_LINEAR) return i;
		if (probe_mode_reg == MODE_QUAD) return i + i * i;
		return 11 * i + 29 * i * i;
	endfunction

	function automatic bit place_sum(input logic b, input int size, input int sum,
			output int slot, output int coll);
		int base, j;
		base = sum % size;
		for (int i = 0; i < size; i++) begin
			j = (base + step_offset(i)) % size;
			if (!banks[b][j][SUM_W]) begin
				banks[b][j] = {1'b1, sum[SUM_W-1:0]};
				slot = j;
				coll = i;
				return 1'b1;
			end
		end
		slot = 0;
		coll = size;
		return 1'b0;
	endfunction

	task automatic clear_table();
		foreach (banks[b, k]) banks[b][k] = '0;
		bank_sel = 1'b0;
		size_now = (init_size_reg == 0) ? 1 :
			(init_size_reg > TABLE_CAPACITY) ? TABLE_CAPACITY : int'(init_size_reg);
		entries = 0;
		key_sum = 0;
		key_len = 0;
		doublings = 0;
		worst_seen = 0;
	endtask

	task automatic double_table();
		int slot, coll;
		logic dst;
		dst = ~bank_sel;
		for (int k = 0; k < TABLE_CAPACITY; k++) banks[dst][k] = '0;
		for (int k = 0; k < size_now; k++)
			if (banks[bank_sel][k][SUM_W])
				if (!place_sum(dst, size_now * 2, int'(banks[bank_sel][k][SUM_W-1:0]),
						slot, coll) && entries > 0)
					entries--;
		bank_sel = dst;
		size_now = size_now * 2;
	endtask

	task automatic take_item(input logic req, input logic [7:0] kbyte, input logic klast);
		insert_result_t r;
		int sum, slot, coll;
		if (req == REQ_CLEAR) begin
			clear_table();
			return;
		end
		if (key_len < MAX_KEY_LEN) begin
			key_len++;
			key_sum += kbyte;
			if (key_sum > int'(SUM_LIMIT)) key_sum = int'(SUM_LIMIT);
		end
		if (!klast) return;
		sum = key_sum;
		key_sum = 0;
		key_len = 0;
		r = '0;
		r.status = ST_OK;
		if (longint'(entries) * 256 > longint'(fill_limit_reg) * size_now) begin
			if (size_now * 2 <= TABLE_CAPACITY) begin
				double_table();
				r.grew = 1'b1;
				if (doublings < 15) doublings++;
			end else begin
				r.status = ST_REFUSED;
			end
		end
		if (place_sum(bank_sel, size_now, sum, slot, coll)) begin
			if (entries < 'h7FF) entries++;
			if (coll > worst_seen) worst_seen = coll;
		end else begin
			r.status = ST_FULL;
		end
		r.slot = slot[9:0];
		r.coll = coll[10:0];
		r.size = size_now[10:0];
		r.resizes = doublings[3:0];
		r.worst = worst_seen[10:0];
		placements.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		insert_result_t want;
		if (!arst_n) begin
			init_size_reg = 11'd16;
			fill_limit_reg = 9'd192;
			probe_mode_reg = 2'd2;
			clear_table();
			placements.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_INITIAL_SIZE: init_size_reg = cfg_data;
				CFG_FILL_LIMIT: fill_limit_reg = cfg_data[8:0];
				CFG_PROBE_MODE: probe_mode_reg = cfg_data[1:0];
				default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (placements.size() == 0) begin
					report("unexpected result", int'(m_tdata[9:0]), -1);
				end else begin
					want = placements.pop_front();
					if (m_tdata[9:0] !== want.slot)
						report("slot_index", int'(m_tdata[9:0]), int'(want.slot));
					if (m_tdata[20:10] !== want.coll)
						report("collision_count", int'(m_tdata[20:10]), int'(want.coll));
					if (m_tdata[21] !== want.grew)
						report("grew_now", int'(m_tdata[21]), int'(want.grew));
					if (m_tdata[32:22] !== want.size)
						report("table_size_now", int'(m_tdata[32:22]), int'(want.size));
					if (m_tdata[36:33] !== want.resizes)
						report("resize_total", int'(m_tdata[36:33]), int'(want.resizes));
					if (m_tdata[47:37] !== want.worst)
						report("worst_collisions", int'(m_tdata[47:37]), int'(want.worst));
					if (m_tdata[49:48] !== want.status)
						report("insert_status", int'(m_tdata[49:48]), int'(want.status));
					if (m_tdata[OUT_DATA_W-1:50] !== '0)
						report("zero fill", int'(m_tdata[OUT_DATA_W-1:50]), 0);
				end
			end
			if (s_tvalid && s_tready) take_item(s_tuser, s_tdata, s_tlast);
		end
		pending = placements.size();
	end
endmodule
`default_nettype wire

// File: dv/tb.sv
// Top of the hash insert testbench: drives keys, clears and register writes in phases
// with varying idling, and gives the verdict. Depends on ohi_pkg, ohi_checker and the RTL.
`default_nettype none
module tb
	import ohi_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic       REQ_KEY     = ~REQ_CLEAR;
	localparam logic [1:0] MODE_WIDE   = 2'd2;
	localparam logic [1:0] MODE_RSVD   = 2'd3;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tlast, s_tuser;
	logic [7:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [10:0] cfg_data;
	int fails, pending;
	int send_idle_pct, stall_pct, hold_req, hold_left, keys_sent;

	open_addressing_hash_insert DUT (.*);

	ohi_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("FAIL");
		$finish;
	end

	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(input logic req, input logic [7:0] kbyte, input logic klast);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= kbyte;
		s_tlast <= klast;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_key(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
			0: b = 8'h00;
			1: b = 8'hFF;
			default: b = 8'($urandom_range(255));
			endcase
			send(REQ_KEY, b, i == len - 1);
		end
		keys_sent++;
	endtask

	task automatic random_keys(input int n);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(39))
			0: send(REQ_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
			1: send_key(int'($urandom_range(40, 33)));
			default: send_key(int'($urandom_range(4, 1)));
			endcase
		end
	endtask

	task automatic setup_phase(input int isz, input int flim, input logic [1:0] mode,
			input int idle, input int stall);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (1200) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_INITIAL_SIZE;
		cfg_data <= 11'(isz);
		@(negedge clk);
		cfg_index <= CFG_FILL_LIMIT;
		cfg_data <= 11'(flim);
		@(negedge clk);
		cfg_index <= CFG_PROBE_MODE;
		cfg_data <= 11'(mode);
		@(negedge clk);
		cfg_we <= 1'b0;
		send_idle_pct = idle;
		stall_pct = stall;
		send(REQ_CLEAR, 8'h00, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = REQ_CLEAR;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_INITIAL_SIZE;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		keys_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(REQ_KEY, 8'hFF, 1'b1);
		send(REQ_KEY, 8'h00, 1'b1);
		send_key(3);
		send(REQ_KEY, 8'hAA, 1'b0);
		send(REQ_KEY, 8'h55, 1'b1);
		for (int i = 0; i < 35; i++) send(REQ_KEY, 8'hFF, i == 34);
		send(REQ_KEY, 8'h11, 1'b0);
		send(REQ_CLEAR, 8'hFF, 1'b1);
		for (int i = 0; i < 12; i++) send(REQ_KEY, 8'h10, 1'b1);

		setup_phase(4, 511, MODE_LINEAR, 74, 0);
		random_keys(24);
		setup_phase(1, 1, MODE_QUAD, 0, 74);
		random_keys(32);
		setup_phase(512, 1, MODE_RSVD, 35, 35);
		random_keys(12);
		setup_phase(0, 0, MODE_WIDE, 0, 0);
		hold_req = 400;
		random_keys(32);
		setup_phase(2047, 256, MODE_QUAD, 74, 0);
		random_keys(16);
		setup_phase(16, 192, MODE_WIDE, 0, 74);
		random_keys(40);
		setup_phase(8, 64, MODE_LINEAR, 35, 35);
		random_keys(40);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (2000) @(posedge clk);
		$display("Covered %0d keys over eight register settings, growth up to the full table,",
			keys_sent);
		$display("refused growth, full tables, long keys, clears and varied stalls.");
		if (fails == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
